// ===== rtl/affine_from_triangle_pair_assert.svh =====
// Assertion macros for the affine setup block.
`ifndef AFFINE_FROM_TRIANGLE_PAIR_ASSERT_SVH
`define AFFINE_FROM_TRIANGLE_PAIR_ASSERT_SVH

// same-cycle implication, masked during reset
`define AFP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("afp assertion failed");

// next-cycle implication, masked during reset
`define AFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("afp assertion failed");

// next-cycle implication, live during reset
`define AFP_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("afp assertion failed");

`endif

// ===== rtl/afp_pkg.sv =====
`timescale 1ns / 1ps
package afp_pkg;

  localparam int CW        = 16;
  localparam int DW        = CW + 1;
  localparam int PW        = 2 * DW;
  localparam int NW        = PW + 1;
  localparam int MW        = NW;
  localparam int FRAC      = 16;
  localparam int QW        = 32;
  localparam int NNW       = QW + 20;
  localparam int PRW       = QW + CW;
  localparam int TW        = PRW + 2;
  localparam int LANES     = 4;
  localparam int FRONT_LAT = 4;
  localparam int DIV_LAT   = QW + 2;
  localparam int SHIFT_LAT = 3;
  localparam int TOTAL_LAT = FRONT_LAT + DIV_LAT + SHIFT_LAT;

  typedef enum logic [1:0] {
    LANE_XX = 2'd0,
    LANE_XY = 2'd1,
    LANE_YX = 2'd2,
    LANE_YY = 2'd3
  } lane_t;

  typedef struct packed {
    logic signed [CW-1:0] src_x0;
    logic signed [CW-1:0] src_y0;
    logic signed [CW-1:0] src_x1;
    logic signed [CW-1:0] src_y1;
    logic signed [CW-1:0] src_x2;
    logic signed [CW-1:0] src_y2;
    logic signed [CW-1:0] dst_x0;
    logic signed [CW-1:0] dst_y0;
    logic signed [CW-1:0] dst_x1;
    logic signed [CW-1:0] dst_y1;
    logic signed [CW-1:0] dst_x2;
    logic signed [CW-1:0] dst_y2;
  } in_item_t;

  typedef struct packed {
    logic signed [QW-1:0] coef_xx;
    logic signed [QW-1:0] coef_xy;
    logic signed [QW-1:0] shift_x;
    logic signed [QW-1:0] coef_yx;
    logic signed [QW-1:0] coef_yy;
    logic signed [QW-1:0] shift_y;
    logic                 degenerate;
  } out_item_t;

  typedef struct packed {
    logic [NNW-1:0] n;
    logic [MW-1:0]  md;
    logic           neg;
  } div_in_t;

  typedef struct packed {
    logic                 degen;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic signed [CW-1:0] u0;
    logic signed [CW-1:0] v0;
  } side_t;

endpackage

// ===== rtl/afp_ifs.sv =====
`timescale 1ns / 1ps
interface afp_in_if;
  logic               valid;
  logic               ready;
  afp_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface afp_out_if;
  logic               valid;
  logic               ready;
  afp_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/affine_from_triangle_pair.sv =====
`timescale 1ns / 1ps
// channel | dir | handshake   | payload
// in_ch   | in  | valid/ready | src_x0..src_y2, dst_x0..dst_y2 (Q12.4)
// out_ch  | out | valid/ready | coef_xx..shift_y (Q16.16), degenerate
//
// One transaction per cycle while out_ch does not stall; setup, then the
// restoring dividers at one quotient bit per stage, then translation.
// Synchronous active-low reset clears the valid bits only.
// A stall on out_ch freezes every stage; in_ch.ready drops only while a
// result waits at the output.
module affine_from_triangle_pair (
  input  logic       clk,
  input  logic       rst_n,
  afp_in_if.sink     in_ch,
  afp_out_if.source  out_ch
);
  localparam int TOTAL = afp_pkg::TOTAL_LAT;
  localparam int DLAT  = afp_pkg::DIV_LAT;

  logic en;
  logic vld_r [TOTAL];

  afp_pkg::div_in_t            lane [afp_pkg::LANES];
  afp_pkg::side_t              side_f;
  logic signed [afp_pkg::QW-1:0] coef [afp_pkg::LANES];
  afp_pkg::side_t              side_r [DLAT];
  afp_pkg::out_item_t          res;

  assign en          = !vld_r[TOTAL-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOTAL; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_ch.valid;
      for (int i = 1; i < TOTAL; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  afp_front u_front (
    .clk  (clk),
    .en   (en),
    .item (in_ch.data),
    .lane (lane),
    .side (side_f)
  );

  for (genvar g = 0; g < afp_pkg::LANES; g++) begin : g_lane
    afp_div u_div (
      .clk  (clk),
      .en   (en),
      .din  (lane[g]),
      .coef (coef[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_f;
      for (int i = 1; i < DLAT; i++) side_r[i] <= side_r[i-1];
    end
  end

  afp_shift u_shift (
    .clk  (clk),
    .en   (en),
    .coef (coef),
    .side (side_r[DLAT-1]),
    .res  (res)
  );

  assign out_ch.valid = vld_r[TOTAL-1];
  assign out_ch.data  = res;
endmodule

// ===== rtl/afp_front.sv =====
`timescale 1ns / 1ps
module afp_front (
  input  logic               clk,
  input  logic               en,
  input  afp_pkg::in_item_t  item,
  output afp_pkg::div_in_t   lane [afp_pkg::LANES],
  output afp_pkg::side_t     side
);
  localparam int DW  = afp_pkg::DW;
  localparam int PW  = afp_pkg::PW;
  localparam int NW  = afp_pkg::NW;
  localparam int MW  = afp_pkg::MW;
  localparam int NNW = afp_pkg::NNW;

  // stage 1: differences
  logic signed [DW-1:0] ax_r, bx_r, ay_r, by_r, du1_r, du2_r, dv1_r, dv2_r;
  afp_pkg::side_t       s1_r, s2_r, s3_r, s4_r;
  // stage 2: products
  logic signed [PW-1:0] pd0_r, pd1_r;
  logic signed [PW-1:0] pa_r [afp_pkg::LANES];
  logic signed [PW-1:0] pb_r [afp_pkg::LANES];
  // stage 3: determinant and numerators
  logic signed [NW-1:0] det_r;
  logic signed [NW-1:0] num_r [afp_pkg::LANES];
  // stage 4: magnitudes
  afp_pkg::div_in_t     lane_r [afp_pkg::LANES];

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r  <= DW'(item.src_x0) - DW'(item.src_x1);
      bx_r  <= DW'(item.src_x0) - DW'(item.src_x2);
      ay_r  <= DW'(item.src_y0) - DW'(item.src_y1);
      by_r  <= DW'(item.src_y0) - DW'(item.src_y2);
      du1_r <= DW'(item.dst_x0) - DW'(item.dst_x1);
      du2_r <= DW'(item.dst_x0) - DW'(item.dst_x2);
      dv1_r <= DW'(item.dst_y0) - DW'(item.dst_y1);
      dv2_r <= DW'(item.dst_y0) - DW'(item.dst_y2);
      s1_r.degen <= 1'b0;
      s1_r.x0    <= item.src_x0;
      s1_r.y0    <= item.src_y0;
      s1_r.u0    <= item.dst_x0;
      s1_r.v0    <= item.dst_y0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd0_r <= PW'(ax_r) * PW'(by_r);
      pd1_r <= PW'(bx_r) * PW'(ay_r);
      pa_r[afp_pkg::LANE_XX] <= PW'(du1_r) * PW'(by_r);
      pb_r[afp_pkg::LANE_XX] <= PW'(du2_r) * PW'(ay_r);
      pa_r[afp_pkg::LANE_XY] <= PW'(du2_r) * PW'(ax_r);
      pb_r[afp_pkg::LANE_XY] <= PW'(du1_r) * PW'(bx_r);
      pa_r[afp_pkg::LANE_YX] <= PW'(dv1_r) * PW'(by_r);
      pb_r[afp_pkg::LANE_YX] <= PW'(dv2_r) * PW'(ay_r);
      pa_r[afp_pkg::LANE_YY] <= PW'(dv2_r) * PW'(ax_r);
      pb_r[afp_pkg::LANE_YY] <= PW'(dv1_r) * PW'(bx_r);
      s2_r <= s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= NW'(pd0_r) - NW'(pd1_r);
      for (int i = 0; i < afp_pkg::LANES; i++) begin
        num_r[i] <= NW'(pa_r[i]) - NW'(pb_r[i]);
      end
      s3_r.degen <= (pd0_r == pd1_r);
      s3_r.x0    <= s2_r.x0;
      s3_r.y0    <= s2_r.y0;
      s3_r.u0    <= s2_r.u0;
      s3_r.v0    <= s2_r.v0;
    end
  end

  logic [MW-1:0] md;
  logic [MW-1:0] mag [afp_pkg::LANES];

  always_comb begin
    md = det_r[NW-1] ? MW'(-det_r) : MW'(det_r);
    for (int i = 0; i < afp_pkg::LANES; i++) begin
      mag[i] = num_r[i][NW-1] ? MW'(-num_r[i]) : MW'(num_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < afp_pkg::LANES; i++) begin
        lane_r[i].n   <= (NNW'(mag[i]) << afp_pkg::FRAC) + NNW'(md >> 1);
        lane_r[i].md  <= md;
        lane_r[i].neg <= num_r[i][NW-1] ^ det_r[NW-1];
      end
      s4_r <= s3_r;
    end
  end

  assign lane = lane_r;
  assign side = s4_r;
endmodule

// ===== rtl/afp_div.sv =====
`timescale 1ns / 1ps
module afp_div (
  input  logic                          clk,
  input  logic                          en,
  input  afp_pkg::div_in_t              din,
  output logic signed [afp_pkg::QW-1:0] coef
);
  localparam int QW  = afp_pkg::QW;
  localparam int MW  = afp_pkg::MW;
  localparam int NNW = afp_pkg::NNW;

  logic [MW-1:0] rem_r [QW+1];
  logic [QW-1:0] low_r [QW+1];
  logic [QW-1:0] quo_r [QW+1];
  logic [MW-1:0] md_r  [QW+1];
  logic          neg_r [QW+1];
  logic          ovf_r [QW+1];
  logic signed [QW-1:0] coef_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= MW'(din.n[NNW-1:QW]);
      low_r[0] <= din.n[QW-1:0];
      quo_r[0] <= '0;
      md_r[0]  <= din.md;
      neg_r[0] <= din.neg;
      ovf_r[0] <= MW'(din.n[NNW-1:QW]) >= din.md;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [MW:0]   trial;
    logic          ge;
    logic [QW-1:0] quo_nxt;
    always_comb begin
      trial = {rem_r[k], low_r[k][QW-1-k]};
      ge    = trial >= {1'b0, md_r[k]};
      quo_nxt = quo_r[k];
      quo_nxt[QW-1-k] = ge;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? MW'(trial - {1'b0, md_r[k]}) : MW'(trial);
        low_r[k+1] <= low_r[k];
        quo_r[k+1] <= quo_nxt;
        md_r[k+1]  <= md_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  localparam logic [QW-1:0] SAT_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] SAT_MIN = {1'b1, {(QW-1){1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_r[QW]) begin
        if (ovf_r[QW] || quo_r[QW] > SAT_MIN) coef_r <= SAT_MIN;
        else                                  coef_r <= -quo_r[QW];
      end else begin
        if (ovf_r[QW] || quo_r[QW][QW-1]) coef_r <= SAT_MAX;
        else                              coef_r <= quo_r[QW];
      end
    end
  end

  assign coef = coef_r;
endmodule

// ===== rtl/afp_shift.sv =====
`timescale 1ns / 1ps
module afp_shift (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [afp_pkg::QW-1:0] coef [afp_pkg::LANES],
  input  afp_pkg::side_t                side,
  output afp_pkg::out_item_t            res
);
  localparam int QW  = afp_pkg::QW;
  localparam int PRW = afp_pkg::PRW;
  localparam int TW  = afp_pkg::TW;
  localparam logic [TW-1:0] SAT_MAX = TW'({1'b0, {(QW-1){1'b1}}});
  localparam logic [TW-1:0] SAT_MIN = TW'({1'b1, {(QW-1){1'b0}}});

  function automatic logic signed [QW-1:0] rnd_sat(input logic signed [TW-1:0] t);
    logic [TW-1:0] m;
    logic [TW-1:0] r;
    logic signed [QW-1:0] v;
    m = t[TW-1] ? TW'(-t) : TW'(t);
    r = (m + TW'(8)) >> 4;
    if (t[TW-1]) v = (r > SAT_MIN) ? QW'(SAT_MIN) : -QW'(r);
    else         v = (r > SAT_MAX) ? QW'(SAT_MAX) : QW'(r);
    return v;
  endfunction

  logic signed [PRW-1:0] pxx_r, pxy_r, pyx_r, pyy_r;
  logic signed [QW-1:0]  c1_r [afp_pkg::LANES];
  logic signed [QW-1:0]  c2_r [afp_pkg::LANES];
  afp_pkg::side_t        s1_r, s2_r;
  logic signed [TW-1:0]  tx_r, ty_r;
  afp_pkg::out_item_t    res_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pxx_r <= PRW'(coef[afp_pkg::LANE_XX]) * PRW'(side.x0);
      pxy_r <= PRW'(coef[afp_pkg::LANE_XY]) * PRW'(side.y0);
      pyx_r <= PRW'(coef[afp_pkg::LANE_YX]) * PRW'(side.x0);
      pyy_r <= PRW'(coef[afp_pkg::LANE_YY]) * PRW'(side.y0);
      c1_r  <= coef;
      s1_r  <= side;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tx_r <= (TW'(s1_r.u0) <<< afp_pkg::FRAC) - TW'(pxx_r) - TW'(pxy_r);
      ty_r <= (TW'(s1_r.v0) <<< afp_pkg::FRAC) - TW'(pyx_r) - TW'(pyy_r);
      c2_r <= c1_r;
      s2_r <= s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s2_r.degen) begin
        res_r.coef_xx    <= '0;
        res_r.coef_xy    <= '0;
        res_r.shift_x    <= '0;
        res_r.coef_yx    <= '0;
        res_r.coef_yy    <= '0;
        res_r.shift_y    <= '0;
        res_r.degenerate <= 1'b1;
      end else begin
        res_r.coef_xx    <= c2_r[afp_pkg::LANE_XX];
        res_r.coef_xy    <= c2_r[afp_pkg::LANE_XY];
        res_r.shift_x    <= rnd_sat(tx_r);
        res_r.coef_yx    <= c2_r[afp_pkg::LANE_YX];
        res_r.coef_yy    <= c2_r[afp_pkg::LANE_YY];
        res_r.shift_y    <= rnd_sat(ty_r);
        res_r.degenerate <= 1'b0;
      end
    end
  end

  assign res = res_r;
endmodule

// ===== rtl/afp_checker.sv =====
`timescale 1ns / 1ps
`include "affine_from_triangle_pair_assert.svh"
module afp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input afp_pkg::out_item_t out_data
);
  `AFP_ASSERT_IMPL(a_degen_zero, out_valid && out_data.degenerate, out_data.coef_xx == 0 && out_data.coef_xy == 0 && out_data.shift_x == 0 && out_data.coef_yx == 0 && out_data.coef_yy == 0 && out_data.shift_y == 0)
  `AFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `AFP_ASSERT_IMPL(a_ready_free, !out_valid || out_ready, in_ready)
  `AFP_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)
endmodule

bind affine_from_triangle_pair afp_checker u_afp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
